### hw/rtl/brfb_pkg.sv
// Package with the item types, action codes and state codes of the byte ring FIFO.
`timescale 1ns / 1ps

package brfb_pkg;

   // Field widths that the interface fixes.
   localparam int COUNT_W   = 7;
   localparam int DATA_W    = 8;
   localparam int LEVEL_W   = 6;
   localparam int CAP_REG_W = 7;

   // Action codes carried by an input item.
   typedef enum logic [1:0] {
      ACT_WRITE  = 2'd0,
      ACT_READ   = 2'd1,
      ACT_CLEAR  = 2'd2,
      ACT_STATUS = 2'd3
   } action_type;

   // Sequencer states.
   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_READ = 1'b1
   } state_type;

   // One input item.
   typedef struct packed {
      action_type                 action;
      logic                       batch_start;
      logic [COUNT_W-1:0]         transfer_count;
      logic [DATA_W-1:0]          data_in;
   } req_type;

   // One result item.
   typedef struct packed {
      logic                       ok;
      logic                       data_valid;
      logic [DATA_W-1:0]          data_out;
      logic                       last;
      logic [LEVEL_W-1:0]         fill_level;
      logic [LEVEL_W-1:0]         free_space;
   } rsp_type;

endpackage

### hw/rtl/byte_ring_fifo_batch_unit.sv
// Top level of the byte ring FIFO with all-or-nothing write batches.
`timescale 1ns / 1ps

// Usage:
// An item on the req_ channel is a byte write, a read batch, a pointer clear
// or a status query. Results leave on the rsp_ channel through one output
// register, so a new item can be taken in the cycle the previous result leaves.
// For writes, clears, status queries and failed or empty reads, the result
// is registered at the accepting edge and one such item can be accepted
// every cycle while the receiver keeps up.
// A successful read of n bytes first enters the read state, then reads the
// byte store one entry per cycle while the receiver keeps up; each byte
// passes through the RAM read register and then the output register. The
// single read port of the byte store sets that rate.
// When the receiver stalls, the output register holds its result and the
// read sequencer pauses with the next byte parked in the RAM read register.
// The csr_ port writes the slot count; a write also clears both pointers and
// any open batch. Reset sets the full slot count and empty pointers; the
// byte store is not cleared, since no entry is read before it is written.

module byte_ring_fifo_batch_unit #(
   parameter int DEPTH = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  brfb_pkg::req_type                req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output brfb_pkg::rsp_type                rsp_payload,
   input  logic                             csr_write_en,
   input  logic [brfb_pkg::CAP_REG_W-1:0]   csr_write_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CAP_W = $clog2(DEPTH + 1);

   // Registers.
   brfb_pkg::state_type          state_ff, state_in;
   logic [PTR_W-1:0]             wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]             rd_ptr_ff, rd_ptr_in;
   logic [CAP_W-1:0]             cap_ff, cap_in;
   logic                         batch_acc_ff, batch_acc_in;
   logic [brfb_pkg::COUNT_W-1:0] batch_rem_ff, batch_rem_in;
   logic [brfb_pkg::COUNT_W-1:0] rd_left_ff, rd_left_in;
   logic [CAP_W-1:0]             after_fill_ff, after_fill_in;
   logic                         pend_ff, pend_in;
   logic                         pend_last_ff, pend_last_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   brfb_pkg::rsp_type            rsp_ff, rsp_in;

   // RAM port signals.
   logic                         ram_wr_en;
   logic                         ram_rd_en;
   logic [brfb_pkg::DATA_W-1:0]  ram_rd_data;

   // Derived levels.
   logic [CAP_W-1:0]             fill_now;
   logic [CAP_W-1:0]             free_now;
   logic                         out_free;
   logic                         req_fire;

   // Pointer advance with wrap at the slot count.
   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p,
                                             input logic [CAP_W-1:0] c);
      logic [CAP_W-1:0] n;
      n = CAP_W'(p) + CAP_W'(1);
      return (n >= c) ? '0 : n[PTR_W-1:0];
   endfunction

   // Clamp a written slot count to the range 2 to DEPTH.
   function automatic logic [CAP_W-1:0] clamp_cap(
         input logic [brfb_pkg::CAP_REG_W-1:0] d);
      logic [brfb_pkg::CAP_REG_W-1:0] c;
      c = d;
      if (d < brfb_pkg::CAP_REG_W'(2)) begin
         c = brfb_pkg::CAP_REG_W'(2);
      end else if (d > brfb_pkg::CAP_REG_W'(DEPTH)) begin
         c = brfb_pkg::CAP_REG_W'(DEPTH);
      end
      return CAP_W'(c);
   endfunction

   // Fill level and free space from the two pointers.
   always_comb begin
      if (wr_ptr_ff >= rd_ptr_ff) begin
         fill_now = CAP_W'(wr_ptr_ff) - CAP_W'(rd_ptr_ff);
      end else begin
         fill_now = cap_ff + CAP_W'(wr_ptr_ff) - CAP_W'(rd_ptr_ff);
      end
      free_now = cap_ff - CAP_W'(1) - fill_now;
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == brfb_pkg::ST_IDLE) && out_free;
   assign req_fire  = req_valid && req_ready;

   // Next state, pointers, RAM control and result.
   always_comb begin
      logic                         store;
      logic                         ok;
      logic [CAP_W-1:0]             rsp_fill;
      logic [brfb_pkg::COUNT_W-1:0] rem_base;
      logic                         rsp_load;
      logic                         issue;

      state_in      = state_ff;
      wr_ptr_in     = wr_ptr_ff;
      rd_ptr_in     = rd_ptr_ff;
      cap_in        = cap_ff;
      batch_acc_in  = batch_acc_ff;
      batch_rem_in  = batch_rem_ff;
      rd_left_in    = rd_left_ff;
      after_fill_in = after_fill_ff;
      pend_in       = pend_ff;
      pend_last_in  = pend_last_ff;
      rsp_in        = rsp_ff;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      store         = 1'b0;
      ok            = 1'b1;
      rsp_fill      = fill_now;
      rem_base      = batch_rem_ff;
      rsp_load      = 1'b0;
      issue         = 1'b0;

      unique case (state_ff)
         brfb_pkg::ST_IDLE: begin
            if (req_fire) begin
               rsp_load = 1'b1;
               unique case (req_payload.action)
                  brfb_pkg::ACT_WRITE: begin
                     // A first byte opens or rejects a batch.
                     if (req_payload.batch_start) begin
                        rem_base = req_payload.transfer_count;
                        if (brfb_pkg::COUNT_W'(free_now) >= req_payload.transfer_count)
                        begin
                           batch_acc_in = 1'b1;
                           batch_rem_in = req_payload.transfer_count;
                           store        = (req_payload.transfer_count != '0);
                        end else begin
                           batch_acc_in = 1'b0;
                           batch_rem_in = '0;
                           ok           = 1'b0;
                        end
                     end else begin
                        store = batch_acc_ff && (batch_rem_ff != '0);
                        ok    = store;
                     end
                     if (store && (free_now != '0)) begin
                        ram_wr_en    = 1'b1;
                        wr_ptr_in    = bump(wr_ptr_ff, cap_ff);
                        batch_rem_in = rem_base - brfb_pkg::COUNT_W'(1);
                        rsp_fill     = fill_now + CAP_W'(1);
                     end
                  end
                  brfb_pkg::ACT_READ: begin
                     // A read that can be served hands over to the sequencer.
                     if ((req_payload.transfer_count != '0) &&
                         (brfb_pkg::COUNT_W'(fill_now) >= req_payload.transfer_count))
                     begin
                        rsp_load      = 1'b0;
                        state_in      = brfb_pkg::ST_READ;
                        rd_left_in    = req_payload.transfer_count;
                        after_fill_in = fill_now - CAP_W'(req_payload.transfer_count);
                     end else begin
                        ok = (req_payload.transfer_count == '0);
                     end
                  end
                  brfb_pkg::ACT_CLEAR: begin
                     wr_ptr_in = '0;
                     rd_ptr_in = '0;
                     rsp_fill  = '0;
                  end
                  brfb_pkg::ACT_STATUS: begin
                     rsp_fill = fill_now;
                  end
                  default: begin
                     rsp_fill = fill_now;
                  end
               endcase
               rsp_in.ok         = ok;
               rsp_in.data_valid = 1'b0;
               rsp_in.data_out   = '0;
               rsp_in.last       = 1'b1;
               rsp_in.fill_level = brfb_pkg::LEVEL_W'(rsp_fill);
               rsp_in.free_space = brfb_pkg::LEVEL_W'(cap_ff - CAP_W'(1) - rsp_fill);
            end
         end
         brfb_pkg::ST_READ: begin
            // Issue the next RAM read when the parked byte moves on.
            issue = (rd_left_ff != '0) && (!pend_ff || out_free);
            if (issue) begin
               ram_rd_en    = 1'b1;
               rd_ptr_in    = bump(rd_ptr_ff, cap_ff);
               rd_left_in   = rd_left_ff - brfb_pkg::COUNT_W'(1);
               pend_last_in = (rd_left_ff == brfb_pkg::COUNT_W'(1));
            end
            pend_in = issue || (pend_ff && !out_free);
            // Move the byte from the RAM read register to the output.
            if (pend_ff && out_free) begin
               rsp_load          = 1'b1;
               rsp_in.ok         = 1'b1;
               rsp_in.data_valid = 1'b1;
               rsp_in.data_out   = ram_rd_data;
               rsp_in.last       = pend_last_ff;
               rsp_in.fill_level = brfb_pkg::LEVEL_W'(after_fill_ff);
               rsp_in.free_space = brfb_pkg::LEVEL_W'(cap_ff - CAP_W'(1) - after_fill_ff);
               if (pend_last_ff) begin
                  state_in = brfb_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = brfb_pkg::ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

      // A slot count write restarts the FIFO.
      if (csr_write_en) begin
         cap_in       = clamp_cap(csr_write_data);
         wr_ptr_in    = '0;
         rd_ptr_in    = '0;
         batch_acc_in = 1'b0;
         batch_rem_in = '0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= brfb_pkg::ST_IDLE;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         cap_ff       <= CAP_W'(DEPTH);
         batch_acc_ff <= 1'b0;
         batch_rem_ff <= '0;
         rd_left_ff   <= '0;
         pend_ff      <= 1'b0;
         pend_last_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         cap_ff       <= cap_in;
         batch_acc_ff <= batch_acc_in;
         batch_rem_ff <= batch_rem_in;
         rd_left_ff   <= rd_left_in;
         pend_ff      <= pend_in;
         pend_last_ff <= pend_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      after_fill_ff <= after_fill_in;
      rsp_ff        <= rsp_in;
   end

   // Byte store.
   brfb_ram #(
      .WIDTH (brfb_pkg::DATA_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_ptr_ff),
      .wr_data (req_payload.data_in),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Both pointers stay below the slot count.
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (CAP_W'(wr_ptr_ff) < cap_ff) && (CAP_W'(rd_ptr_ff) < cap_ff))
      else $error("FIFO pointer beyond slot count");

   // One slot always stays empty.
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_now < cap_ff)
      else $error("FIFO fill level reached slot count");

   // The sequencer leaves no read in flight when it returns to idle.
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == brfb_pkg::ST_IDLE) |-> (!pend_ff && (rd_left_ff == '0)))
      else $error("Read still in flight while idle");

   // No byte is written while a read batch drains.
   a_no_write_in_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == brfb_pkg::ST_READ) |=> $stable(wr_ptr_ff) || $past(csr_write_en))
      else $error("Write pointer moved during a read batch");

endmodule

### hw/rtl/brfb_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module brfb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data register holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
